// ===== src/shifting_indexed_list_top_assert.svh =====
// Assertion macros shared by the checker of shifting_indexed_list_top.
// Expects signals named clk and rst_n in the scope of use.
`ifndef SHIFTING_INDEXED_LIST_TOP_ASSERT_SVH
`define SHIFTING_INDEXED_LIST_TOP_ASSERT_SVH

// same-cycle implication
`define SIL_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define SIL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/sil_pkg.sv =====
// Package for the shifting indexed list: request and status codes,
// controller state and the command/flag structs between controller and datapath.
package sil_pkg;

    localparam int SIL_CAPACITY  = 16;
    localparam int SIL_WORD_BITS = 32;
    localparam int SIL_IN_BITS   = 40;
    localparam int SIL_OUT_BITS  = 40;

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_WRITE  = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic {
        CS_EMPTY,
        CS_HELD
    } ctrl_state_t;

    typedef struct packed {
        logic    exec;
        op_t     op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic ins_ok;
        logic idx_ok;
    } dp_flags_t;

endpackage

// ===== src/sil_ctrl.sv =====
// Controller of the shifting indexed list: handshake, result hold state and
// request decode. Depends on sil_pkg.
module sil_ctrl
    import sil_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  dp_flags_t   flags,
    output dp_cmd_t     cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = (state_reg == CS_EMPTY) || out_ready;
        out_valid  = (state_reg == CS_HELD);
        cmd.exec   = in_valid && in_ready;
        cmd.op     = OP_NOP;
        cmd.status = ST_OK;
        state_next = state_reg;

        case (kind)
            KIND_APPEND:
            begin
                if (flags.full) cmd.status = ST_FULL;
                else            cmd.op     = OP_APPEND;
            end
            KIND_INSERT:
            begin
                if (flags.full)         cmd.status = ST_FULL;
                else if (!flags.ins_ok) cmd.status = ST_RANGE;
                else                    cmd.op     = OP_INSERT;
            end
            KIND_REMOVE:
            begin
                if (flags.idx_ok) cmd.op     = OP_REMOVE;
                else              cmd.status = ST_RANGE;
            end
            KIND_WRITE:
            begin
                if (flags.idx_ok) cmd.op     = OP_WRITE;
                else              cmd.status = ST_RANGE;
            end
            KIND_READ:
            begin
                if (flags.idx_ok) cmd.op     = OP_READ;
                else              cmd.status = ST_RANGE;
            end
            default:
            begin
                cmd.op     = OP_NOP;
                cmd.status = ST_OK;
            end
        endcase

        if (cmd.exec)
        begin
            state_next = CS_HELD;
        end
        else if (out_ready)
        begin
            state_next = CS_EMPTY;
        end
    end

endmodule

// ===== src/sil_dp.sv =====
// Datapath of the shifting indexed list: the shifting cell row, entry count
// and result registers. Depends on sil_pkg.
module sil_dp
    import sil_pkg::*;
#(
    parameter int CAPACITY  = SIL_CAPACITY,
    parameter int WORD_BITS = SIL_WORD_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output dp_flags_t          flags,
    output logic signed [31:0] data,
    output logic [4:0]         count,
    output logic [1:0]         status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [WORD_BITS-1:0] cells_reg [CAPACITY];
    logic [WORD_BITS-1:0] cells_next [CAPACITY];
    logic [CW-1:0]        count_reg, count_next;
    logic [31:0]          data_reg, data_next;
    status_t              status_reg;

    logic [CMPW-1:0]      pos_c, cnt_c;
    logic [63:0]          value_w, rd_w, cnt_w;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] rd_word;

    always_comb
    begin
        pos_c   = CMPW'(position);
        cnt_c   = CMPW'(count_reg);
        value_w = 64'($unsigned(value));
        word    = value_w[WORD_BITS-1:0];

        flags.full   = (cnt_c >= CMPW'(CAPACITY));
        flags.ins_ok = (pos_c <= cnt_c);
        flags.idx_ok = (pos_c < cnt_c);

        rd_word = cells_reg[pos_c[IW-1:0]];
        rd_w    = 64'(rd_word);
    end

    // each cell keeps, takes its lower or upper neighbor, or takes the new word
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            case (cmd.op)
                OP_APPEND:
                begin
                    if (CMPW'(i) == cnt_c) cells_next[i] = word;
                end
                OP_INSERT:
                begin
                    if (CMPW'(i) == pos_c)
                        cells_next[i] = word;
                    else if (i > 0 && CMPW'(i) > pos_c && CMPW'(i) <= cnt_c)
                        cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
                OP_REMOVE:
                begin
                    if (i < CAPACITY - 1 && CMPW'(i) >= pos_c)
                        cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
                OP_WRITE:
                begin
                    if (CMPW'(i) == pos_c) cells_next[i] = word;
                end
                default:
                begin
                    cells_next[i] = cells_reg[i];
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        data_next  = '0;
        case (cmd.op)
            OP_APPEND, OP_INSERT: count_next = count_reg + CW'(1);
            OP_REMOVE:
            begin
                count_next = count_reg - CW'(1);
                data_next  = rd_w[31:0];
            end
            OP_READ:  data_next = rd_w[31:0];
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
            data_reg   <= data_next;
            status_reg <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        cnt_w  = 64'(count_reg);
        data   = $signed(data_reg);
        count  = cnt_w[4:0];
        status = status_reg;
    end

endmodule

// ===== src/shifting_indexed_list_top.sv =====
// Top level of the shifting indexed list: stream ports, controller and datapath.
// Depends on sil_pkg, sil_ctrl and sil_dp.
//
// A bounded ordered list of signed words with append, insert, remove, overwrite
// and read requests. All cells choose keep, neighbor or new word in parallel, so
// one item is accepted per cycle while the result side does not stall, and its
// result appears on the master side in the next cycle, held in an output
// register. A new item is taken in the same cycle the waiting result is taken.
// Results carry the entry count after the request and a status (ok, full, out
// of range); on error the list is unchanged and data is zero.
module shifting_indexed_list_top
    import sil_pkg::*;
#(
    parameter int CAPACITY  = SIL_CAPACITY,
    parameter int WORD_BITS = SIL_WORD_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SIL_IN_BITS-1:0]  s_tdata,  // kind[2:0], position[7:3], value[39:8]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SIL_OUT_BITS-1:0] m_tdata   // data[31:0], count[36:32], status[38:37]
);

    dp_cmd_t            cmd;
    dp_flags_t          flags;
    logic signed [31:0] data;
    logic [4:0]         count;
    logic [1:0]         status;

    sil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .kind      (s_tdata[2:0]),
        .flags     (flags),
        .cmd       (cmd)
    );

    sil_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .position (s_tdata[7:3]),
        .value    ($signed(s_tdata[39:8])),
        .flags    (flags),
        .data     (data),
        .count    (count),
        .status   (status)
    );

    assign m_tdata = {1'b0, status, count, data};

endmodule

// ===== src/sil_checker.sv =====
// Port checker for shifting_indexed_list_top, bound to the top level.
// Depends on shifting_indexed_list_top_assert.svh and sil_pkg.
`include "shifting_indexed_list_top_assert.svh"

module sil_checker
    import sil_pkg::*;
#(
    parameter int CAPACITY = SIL_CAPACITY
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [SIL_OUT_BITS-1:0] m_tdata
);

    localparam logic [63:0] CAP_W = 64'(CAPACITY);

    `SIL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SIL_ASSERT(a_status_code, m_tvalid, m_tdata[38:37] != 2'd3, "undefined status code")
    `SIL_ASSERT(a_err_zero, m_tvalid && m_tdata[38:37] != ST_OK, m_tdata[31:0] == 32'd0, "nonzero data on error")
    `SIL_ASSERT(a_full_count, m_tvalid && m_tdata[38:37] == ST_FULL, m_tdata[36:32] == CAP_W[4:0], "full status with count below capacity")
    `SIL_ASSERT_NEXT(a_accept_out, s_tvalid && s_tready, m_tvalid, "accepted item gave no result")

endmodule

bind shifting_indexed_list_top sil_checker #(.CAPACITY(CAPACITY)) u_sil_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/shifting_indexed_list_checker.sv =====
// Checker for shifting_indexed_list_top: watches both stream channels, keeps a
// shadow list of its own, predicts each reply and compares it field by field.
// Depends on sil_pkg.
module shifting_indexed_list_checker
    import sil_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [SIL_IN_BITS-1:0]  s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [SIL_OUT_BITS-1:0] m_tdata,
    output int                      mismatches,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  count;
        status_t     status;
    } list_reply_t;

    logic [31:0]  shadow_cells [SIL_CAPACITY];
    int unsigned  shadow_count;
    list_reply_t  replies_due [$];
    int           bad_count;

    function automatic list_reply_t apply_request(kind_t kind, int unsigned pos,
                                                  logic [31:0] value);
        list_reply_t reply;
        int unsigned i;
        reply.word   = '0;
        reply.status = ST_OK;
        case (kind)
            KIND_APPEND:
                if (shadow_count >= SIL_CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    shadow_cells[shadow_count] = value;
                    shadow_count++;
                end
            KIND_INSERT:
                if (shadow_count >= SIL_CAPACITY)
                    reply.status = ST_FULL;
                else if (pos > shadow_count)
                    reply.status = ST_RANGE;
                else
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = value;
                    shadow_count++;
                end
            KIND_REMOVE:
                if (pos >= shadow_count)
                    reply.status = ST_RANGE;
                else
                begin
                    reply.word = shadow_cells[pos];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
            KIND_WRITE:
                if (pos >= shadow_count)
                    reply.status = ST_RANGE;
                else
                    shadow_cells[pos] = value;
            KIND_READ:
                if (pos >= shadow_count)
                    reply.status = ST_RANGE;
                else
                    reply.word = shadow_cells[pos];
            default:
                ;
        endcase
        reply.count = shadow_count[4:0];
        return reply;
    endfunction

    function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
        if (bad_count < 10)
            $display("checker: %s mismatch at %0t ns: expected %h, got %h",
                     field, $time, want, got);
        bad_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t want;
        list_reply_t got;
        if (!rst_n)
        begin
            shadow_count = 0;
            replies_due.delete();
            bad_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.word   = m_tdata[31:0];
                got.count  = m_tdata[36:32];
                got.status = status_t'(m_tdata[38:37]);
                if (replies_due.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("checker: unexpected item at %0t ns: %h", $time, m_tdata);
                    bad_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.word !== want.word)
                        flag_field("data", want.word, got.word);
                    if (got.count !== want.count)
                        flag_field("count", 32'(want.count), 32'(got.count));
                    if (got.status !== want.status)
                        flag_field("status", 32'(want.status), 32'(got.status));
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_request(kind_t'(s_tdata[2:0]),
                                                    32'(s_tdata[7:3]), s_tdata[39:8]));
            outstanding <= replies_due.size();
            mismatches <= bad_count;
        end
    end

endmodule

// ===== tb/sv/tb_shifting_indexed_list_top.sv =====
// Testbench top for shifting_indexed_list_top: clock, reset, directed and random
// list requests with idling on both sides, and the final verdict.
// Depends on sil_pkg, shifting_indexed_list_top and shifting_indexed_list_checker.
module tb_shifting_indexed_list_top
    import sil_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          PHASE_ITEMS    = 333;
    localparam logic [2:0]  KIND_LAST_CODE = 3'd7;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [SIL_IN_BITS-1:0]  s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [SIL_OUT_BITS-1:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int          send_idle;
    int          recv_idle;
    int          cycle_count;
    int unsigned fill_level;
    bit          growing;

    shifting_indexed_list_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    shifting_indexed_list_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // rough occupancy, only to steer positions into range
    task automatic push_item(logic [2:0] kind, logic [4:0] pos, logic [31:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, pos, kind};
        do
            @(posedge clk);
        while (!s_tready);
        case (kind)
            KIND_APPEND: if (fill_level < SIL_CAPACITY) fill_level++;
            KIND_INSERT: if (fill_level < SIL_CAPACITY && pos <= fill_level) fill_level++;
            KIND_REMOVE: if (pos < fill_level) fill_level--;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic push_random();
        logic [2:0]  kind;
        logic [4:0]  pos;
        logic [31:0] value;
        int          pick;
        if ($urandom_range(39) == 0)
            growing = ~growing;
        if (fill_level == 0)
            growing = 1'b1;
        else if (fill_level == SIL_CAPACITY && $urandom_range(3) == 0)
            growing = 1'b0;
        pick = $urandom_range(99);
        if (pick < 4)
            kind = 3'($urandom_range(KIND_READ + 1, KIND_LAST_CODE));
        else if (growing)
            kind = (pick < 34) ? KIND_APPEND : (pick < 62) ? KIND_INSERT :
                   (pick < 72) ? KIND_REMOVE : (pick < 82) ? KIND_WRITE : KIND_READ;
        else
            kind = (pick < 14) ? KIND_APPEND : (pick < 24) ? KIND_INSERT :
                   (pick < 66) ? KIND_REMOVE : (pick < 80) ? KIND_WRITE : KIND_READ;
        if ($urandom_range(9) == 0)
            pos = 5'($urandom_range(SIL_CAPACITY));
        else if (kind == KIND_INSERT)
            pos = 5'($urandom_range(fill_level));
        else if (fill_level > 0)
            pos = 5'($urandom_range(fill_level - 1));
        else
            pos = 5'($urandom_range(SIL_CAPACITY));
        case ($urandom_range(39))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'h0000_0000;
            3:       value = 32'hFFFF_FFFF;
            default: value = $urandom();
        endcase
        push_item(kind, pos, value);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cycle_count = 0;
        fill_level  = 0;
        growing     = 1'b1;
        send_idle   = 6;
        recv_idle   = 84;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, edge indexes, unknown kind, then fill to full and remove the last entry
        push_item(KIND_READ,   5'd0,  32'h0000_0000);
        push_item(KIND_REMOVE, 5'd0,  32'h0000_0000);
        push_item(KIND_INSERT, 5'd1,  32'h1111_1111);
        push_item(KIND_INSERT, 5'd0,  32'h7FFF_FFFF);
        push_item(KIND_APPEND, 5'd16, 32'h8000_0000);
        push_item(KIND_INSERT, 5'd1,  32'hFFFF_FFFF);
        push_item(KIND_LAST_CODE, 5'd16, 32'hFFFF_FFFF);
        push_item(KIND_WRITE,  5'd3,  32'hDEAD_BEEF);
        push_item(KIND_WRITE,  5'd0,  32'h0000_0000);
        push_item(KIND_REMOVE, 5'd1,  32'h0000_0000);
        while (fill_level < SIL_CAPACITY)
            push_item(KIND_APPEND, 5'($urandom_range(31)), $urandom());
        push_item(KIND_APPEND, 5'd0,  32'h5555_5555);
        push_item(KIND_INSERT, 5'd16, 32'hAAAA_AAAA);
        push_item(KIND_READ,   5'd15, 32'h0000_0000);
        push_item(KIND_REMOVE, 5'd15, 32'h0000_0000);
        push_item(KIND_READ,   5'd15, 32'h0000_0000);
        drain();

        repeat (PHASE_ITEMS) push_random();
        drain();
        send_idle = 84;
        recv_idle = 6;
        repeat (PHASE_ITEMS) push_random();
        drain();
        send_idle = 0;
        recv_idle = 0;
        repeat (PHASE_ITEMS) push_random();
        drain();

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sil_pkg.sv
src/sil_ctrl.sv
src/sil_dp.sv
src/shifting_indexed_list_top.sv
src/sil_checker.sv
tb/sv/shifting_indexed_list_checker.sv
tb/sv/tb_shifting_indexed_list_top.sv
